// ===== hw/rtl/assert_macros.svh =====
// assertion macros for the rtl file that checks itself
// no dependencies; NO_ASSERTIONS compiles the checks away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// expression must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clock, resetn, expr) \
    label: assert property (@(posedge clock) disable iff (!(resetn)) (expr)) \
        else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!(resetn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clock, resetn, expr)
`define ASSERT_NEXT(label, clock, resetn, ante, cons)

`endif

`endif

// ===== hw/rtl/ttpp_pkg.sv =====
// shared types and constants of the thread table priority picker
// no dependencies
package ttpp_pkg;

    localparam int CMD_W   = 3;
    localparam int ID_W    = 32;
    localparam int PRIO_W  = 8;
    localparam int STATE_W = 16;
    localparam int SUSP_W  = 32;
    localparam int CFG_IDX_W = 1;

    localparam logic [CMD_W-1:0] CMD_CREATE      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_READ_STATE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE_STATE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_WRITE_SUSP  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PICK        = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_READY_MASK   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RUNNING_MASK = 1'd1;

    localparam logic [STATE_W-1:0] READY_MASK_RST   = 16'd1;
    localparam logic [STATE_W-1:0] RUNNING_MASK_RST = 16'd2;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_last;
    } dp_status_t;

endpackage

// ===== hw/rtl/ttpp_ctrl.sv =====
// controller of the thread table priority picker: scan sequencing and handshakes
// depends on ttpp_pkg
module ttpp_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  ttpp_pkg::dp_status_t sts,
    output ttpp_pkg::dp_cmd_t    ctl
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                ctl.step = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // hold the finished item until the output register is free
                if (out_free)
                begin
                    ctl.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hw/rtl/ttpp_dp.sv =====
// datapath of the thread table priority picker: slot table, scan unit, result register
// depends on ttpp_pkg
module ttpp_dp
#(
    parameter int MAX_THREADS  = 16,
    parameter int PRIORITY_MAX = 31
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  ttpp_pkg::dp_cmd_t                    ctl,
    output ttpp_pkg::dp_status_t                 sts,
    input  logic                                 cfg_we,
    input  logic [ttpp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ttpp_pkg::STATE_W-1:0]         cfg_data,
    input  logic [ttpp_pkg::CMD_W-1:0]           cmd,
    input  logic [ttpp_pkg::ID_W-1:0]            thread_id,
    input  logic [ttpp_pkg::PRIO_W-1:0]          priority_req,
    input  logic [ttpp_pkg::STATE_W-1:0]         new_state,
    input  logic signed [ttpp_pkg::SUSP_W-1:0]   suspend_value,
    output logic                                 ok,
    output logic [ttpp_pkg::STATE_W-1:0]         state_value,
    output logic [ttpp_pkg::ID_W-1:0]            picked_thread
);

    localparam int IDX_W = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_THREADS - 1);
    localparam logic [ttpp_pkg::PRIO_W-1:0] BEST_INIT = ttpp_pkg::PRIO_W'(PRIORITY_MAX + 1);

    // slot table
    logic [MAX_THREADS-1:0]       used_reg;
    logic [ttpp_pkg::ID_W-1:0]    thread_reg [MAX_THREADS];
    logic [ttpp_pkg::STATE_W-1:0] tstate_reg [MAX_THREADS];
    logic [ttpp_pkg::PRIO_W-1:0]  tprio_reg  [MAX_THREADS];
    logic [ttpp_pkg::SUSP_W-1:0]  tsusp_reg  [MAX_THREADS];

    // configuration
    logic [ttpp_pkg::STATE_W-1:0] ready_mask_reg;
    logic [ttpp_pkg::STATE_W-1:0] running_mask_reg;

    // latched item
    logic [ttpp_pkg::CMD_W-1:0]   cmd_reg;
    logic [ttpp_pkg::ID_W-1:0]    id_reg;
    logic [ttpp_pkg::PRIO_W-1:0]  prio_reg;
    logic [ttpp_pkg::STATE_W-1:0] nstate_reg;
    logic [ttpp_pkg::SUSP_W-1:0]  susp_reg;

    // scan state
    logic [IDX_W-1:0]             idx_reg,        idx_next;
    logic                         found_reg,      found_next;
    logic [IDX_W-1:0]             found_idx_reg,  found_idx_next;
    logic [ttpp_pkg::STATE_W-1:0] found_st_reg,   found_st_next;
    logic                         free_vld_reg,   free_vld_next;
    logic [IDX_W-1:0]             free_idx_reg,   free_idx_next;
    logic [ttpp_pkg::PRIO_W-1:0]  best_prio_reg,  best_prio_next;
    logic [ttpp_pkg::ID_W-1:0]    best_id_reg,    best_id_next;

    // result register
    logic                         ok_reg,     ok_next;
    logic [ttpp_pkg::STATE_W-1:0] sv_reg,     sv_next;
    logic [ttpp_pkg::ID_W-1:0]    picked_reg, picked_next;

    // current slot under the scan
    logic                         rd_used;
    logic [ttpp_pkg::ID_W-1:0]    rd_thread;
    logic [ttpp_pkg::STATE_W-1:0] rd_state;
    logic [ttpp_pkg::PRIO_W-1:0]  rd_prio;
    logic [ttpp_pkg::SUSP_W-1:0]  rd_susp;
    logic                         hit;
    logic                         runnable;

    // commit decode
    logic                         id_nz;
    logic                         do_create;
    logic                         do_wstate;
    logic                         do_wsusp;

    assign rd_used   = used_reg[idx_reg];
    assign rd_thread = thread_reg[idx_reg];
    assign rd_state  = tstate_reg[idx_reg];
    assign rd_prio   = tprio_reg[idx_reg];
    assign rd_susp   = tsusp_reg[idx_reg];

    assign hit = rd_used && (rd_thread == id_reg);
    // ready or running, and signed suspend count not above zero
    assign runnable = rd_used
                   && ((rd_state & (ready_mask_reg | running_mask_reg)) != '0)
                   && ((rd_susp == '0) || rd_susp[ttpp_pkg::SUSP_W-1]);

    assign sts.scan_last = (idx_reg == LAST_IDX);

    assign id_nz     = (id_reg != '0);
    assign do_create = ctl.commit && (cmd_reg == ttpp_pkg::CMD_CREATE)
                    && id_nz && !found_reg && free_vld_reg;
    assign do_wstate = ctl.commit && (cmd_reg == ttpp_pkg::CMD_WRITE_STATE)
                    && id_nz && found_reg;
    assign do_wsusp  = ctl.commit && (cmd_reg == ttpp_pkg::CMD_WRITE_SUSP)
                    && id_nz && found_reg;

    always_comb
    begin
        idx_next       = idx_reg;
        found_next     = found_reg;
        found_idx_next = found_idx_reg;
        found_st_next  = found_st_reg;
        free_vld_next  = free_vld_reg;
        free_idx_next  = free_idx_reg;
        best_prio_next = best_prio_reg;
        best_id_next   = best_id_reg;
        if (ctl.load)
        begin
            idx_next       = '0;
            found_next     = 1'b0;
            free_vld_next  = 1'b0;
            best_prio_next = BEST_INIT;
            best_id_next   = '0;
        end
        else if (ctl.step)
        begin
            if (!sts.scan_last)
            begin
                idx_next = idx_reg + 1'b1;
            end
            if (hit && !found_reg)
            begin
                found_next     = 1'b1;
                found_idx_next = idx_reg;
                found_st_next  = rd_state;
            end
            if (!rd_used && !free_vld_reg)
            begin
                free_vld_next = 1'b1;
                free_idx_next = idx_reg;
            end
            // strict compare keeps the lowest slot on a tie
            if (runnable && (rd_prio < best_prio_reg))
            begin
                best_prio_next = rd_prio;
                best_id_next   = rd_thread;
            end
        end
    end

    always_comb
    begin
        ok_next     = ok_reg;
        sv_next     = sv_reg;
        picked_next = picked_reg;
        if (ctl.commit)
        begin
            ok_next     = do_create || do_wstate || do_wsusp;
            sv_next     = '0;
            picked_next = '0;
            case (cmd_reg)
                ttpp_pkg::CMD_READ_STATE:
                begin
                    if (id_nz && found_reg)
                    begin
                        sv_next = found_st_reg;
                    end
                end
                ttpp_pkg::CMD_PICK:
                begin
                    picked_next = best_id_reg;
                end
                default:
                begin
                    sv_next = '0;
                end
            endcase
        end
    end

    assign ok            = ok_reg;
    assign state_value   = sv_reg;
    assign picked_thread = picked_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg         <= '0;
            ready_mask_reg   <= ttpp_pkg::READY_MASK_RST;
            running_mask_reg <= ttpp_pkg::RUNNING_MASK_RST;
            idx_reg          <= '0;
            found_reg        <= 1'b0;
            free_vld_reg     <= 1'b0;
        end
        else
        begin
            if (do_create)
            begin
                used_reg[free_idx_reg] <= 1'b1;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    ttpp_pkg::CFG_READY_MASK:   ready_mask_reg   <= cfg_data;
                    ttpp_pkg::CFG_RUNNING_MASK: running_mask_reg <= cfg_data;
                    default:                    ready_mask_reg   <= ready_mask_reg;
                endcase
            end
            idx_reg      <= idx_next;
            found_reg    <= found_next;
            free_vld_reg <= free_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg    <= cmd;
            id_reg     <= thread_id;
            prio_reg   <= priority_req;
            nstate_reg <= new_state;
            susp_reg   <= suspend_value;
        end
        found_idx_reg <= found_idx_next;
        found_st_reg  <= found_st_next;
        free_idx_reg  <= free_idx_next;
        best_prio_reg <= best_prio_next;
        best_id_reg   <= best_id_next;
        ok_reg        <= ok_next;
        sv_reg        <= sv_next;
        picked_reg    <= picked_next;
        if (do_create)
        begin
            thread_reg[free_idx_reg] <= id_reg;
            tstate_reg[free_idx_reg] <= ready_mask_reg;
            tprio_reg[free_idx_reg]  <= prio_reg;
            tsusp_reg[free_idx_reg]  <= ttpp_pkg::SUSP_W'(1);
        end
        if (do_wstate)
        begin
            tstate_reg[found_idx_reg] <= nstate_reg;
        end
        if (do_wsusp)
        begin
            tsusp_reg[found_idx_reg] <= susp_reg;
        end
    end

endmodule

// ===== hw/rtl/thread_table_priority_picker.sv =====
// an accepted item is loaded, the table is scanned one slot per cycle, and the result is
// committed to the output register once that is free; no new item is taken before the commit
// the next item is taken while a finished result still waits in the output register
// reset: all slots free, ready_mask 1, running_mask 2; no clearing pass
// depends on ttpp_pkg, ttpp_ctrl, ttpp_dp, assert_macros.svh
`include "assert_macros.svh"

module thread_table_priority_picker
#(
    parameter int MAX_THREADS  = 16,
    parameter int PRIORITY_MAX = 31
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ttpp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ttpp_pkg::STATE_W-1:0]         cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [ttpp_pkg::CMD_W-1:0]           cmd,
    input  logic [ttpp_pkg::ID_W-1:0]            thread_id,
    input  logic [ttpp_pkg::PRIO_W-1:0]          priority_req,
    input  logic [ttpp_pkg::STATE_W-1:0]         new_state,
    input  logic signed [ttpp_pkg::SUSP_W-1:0]   suspend_value,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 ok,
    output logic [ttpp_pkg::STATE_W-1:0]         state_value,
    output logic [ttpp_pkg::ID_W-1:0]            picked_thread
);

    ttpp_pkg::dp_cmd_t    ctl;
    ttpp_pkg::dp_status_t sts;

    assign cfg_ready = 1'b1;

    ttpp_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    ttpp_dp
    #(
        .MAX_THREADS  (MAX_THREADS),
        .PRIORITY_MAX (PRIORITY_MAX)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .sts           (sts),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .thread_id     (thread_id),
        .priority_req  (priority_req),
        .new_state     (new_state),
        .suspend_value (suspend_value),
        .ok            (ok),
        .state_value   (state_value),
        .picked_thread (picked_thread)
    );

    // an accepted item blocks the input until it is committed to the output register
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
    // a committed item always shows up on the output
    `ASSERT_NEXT(a_commit_to_out, clk, rst_n, ctl.commit, out_valid)
    // each result carries at most one nonzero field
    `ASSERT_ALWAYS(a_one_field, clk, rst_n, !out_valid || $onehot0({ok, |state_value, |picked_thread}))

endmodule

// ===== tb/sv/tb.sv =====
// self-checking testbench for thread_table_priority_picker: a scheduler-table predictor
// checks every result; depends on ttpp_pkg and the block's rtl
`timescale 1ns / 100ps

module tb;
    import ttpp_pkg::*;

    localparam int MAX_THREADS    = 16;
    localparam int PRIORITY_MAX   = 31;
    localparam int DRAIN_CYCLES   = MAX_THREADS + 2 + 8;
    // longest legal quiet stretch is a result hold-off plus one scan and a gap
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;

    localparam logic [CMD_W-1:0] CMD_RESERVED_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RESERVED_LAST  = 3'd7;

    typedef struct {
        logic [CMD_W-1:0]         cmd;
        logic [ID_W-1:0]          id;
        logic [PRIO_W-1:0]        prio;
        logic [STATE_W-1:0]       nstate;
        logic signed [SUSP_W-1:0] susp;
    } sched_cmd_t;

    typedef struct {
        logic               ok;
        logic [STATE_W-1:0] state_bits;
        logic [ID_W-1:0]    picked_id;
    } sched_resp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [STATE_W-1:0]       cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [CMD_W-1:0]         cmd = '0;
    logic [ID_W-1:0]          thread_id = '0;
    logic [PRIO_W-1:0]        priority_req = '0;
    logic [STATE_W-1:0]       new_state = '0;
    logic signed [SUSP_W-1:0] suspend_value = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic                     ok;
    logic [STATE_W-1:0]       state_value;
    logic [ID_W-1:0]          picked_thread;

    thread_table_priority_picker #(
        .MAX_THREADS  (MAX_THREADS),
        .PRIORITY_MAX (PRIORITY_MAX)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .thread_id     (thread_id),
        .priority_req  (priority_req),
        .new_state     (new_state),
        .suspend_value (suspend_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .ok            (ok),
        .state_value   (state_value),
        .picked_thread (picked_thread)
    );

    // predicted scheduler table and mask registers
    logic                     tbl_used[MAX_THREADS];
    logic [ID_W-1:0]          tbl_id[MAX_THREADS];
    logic [STATE_W-1:0]       tbl_state[MAX_THREADS];
    logic [PRIO_W-1:0]        tbl_prio[MAX_THREADS];
    logic signed [SUSP_W-1:0] tbl_susp[MAX_THREADS];
    logic [STATE_W-1:0]       ready_mask_m = READY_MASK_RST;
    logic [STATE_W-1:0]       running_mask_m = RUNNING_MASK_RST;

    sched_cmd_t  pending_cmds[$];
    sched_resp_t expected_resps[$];
    logic [ID_W-1:0] offered_ids[$];
    sched_cmd_t  drv_cmd;
    sched_resp_t mon_resp;

    int queued_count = 0;
    int accepted_count = 0;
    int results_seen = 0;
    int fail_count = 0;
    int send_gap = 0;
    int stall_left = 0;
    int hold_left = 0;
    int next_hold_mark = 150;
    int quiet_cycles = 0;
    bit calm = 1'b0;
    bit send_now;

    initial begin
        for (int i = 0; i < MAX_THREADS; i++)
            tbl_used[i] = 1'b0;
    end

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic sched_resp_t schedule_command(sched_cmd_t c);
        sched_resp_t r;
        int slot;
        int best_prio;
        bit placed;
        logic [STATE_W-1:0] runnable;
        r.ok = 1'b0;
        r.state_bits = '0;
        r.picked_id = '0;
        slot = -1;
        placed = 1'b0;
        if (c.id != '0)
            for (int i = 0; i < MAX_THREADS; i++)
                if (slot < 0 && tbl_used[i] && tbl_id[i] == c.id)
                    slot = i;
        case (c.cmd)
            CMD_CREATE: begin
                if (c.id != '0 && slot < 0)
                    for (int i = 0; i < MAX_THREADS; i++)
                        if (!placed && !tbl_used[i]) begin
                            placed = 1'b1;
                            tbl_used[i] = 1'b1;
                            tbl_id[i] = c.id;
                            tbl_state[i] = ready_mask_m;
                            tbl_prio[i] = c.prio;
                            tbl_susp[i] = 32'sd1;
                        end
                r.ok = placed;
            end
            CMD_READ_STATE: begin
                if (slot >= 0)
                    r.state_bits = tbl_state[slot];
            end
            CMD_WRITE_STATE: begin
                if (slot >= 0) begin
                    tbl_state[slot] = c.nstate;
                    r.ok = 1'b1;
                end
            end
            CMD_WRITE_SUSP: begin
                if (slot >= 0) begin
                    tbl_susp[slot] = c.susp;
                    r.ok = 1'b1;
                end
            end
            CMD_PICK: begin
                best_prio = PRIORITY_MAX + 1;
                runnable = ready_mask_m | running_mask_m;
                for (int i = 0; i < MAX_THREADS; i++)
                    if (tbl_used[i] && (tbl_state[i] & runnable) != '0
                            && tbl_susp[i] <= 32'sd0 && int'(tbl_prio[i]) < best_prio) begin
                        best_prio = int'(tbl_prio[i]);
                        r.picked_id = tbl_id[i];
                    end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic queue_cmd(input logic [CMD_W-1:0] c, input logic [ID_W-1:0] id,
                             input logic [PRIO_W-1:0] prio, input logic [STATE_W-1:0] ns,
                             input logic signed [SUSP_W-1:0] susp);
        sched_cmd_t item;
        item.cmd = c;
        item.id = id;
        item.prio = prio;
        item.nstate = ns;
        item.susp = susp;
        pending_cmds.push_back(item);
        queued_count++;
    endtask

    function automatic logic [ID_W-1:0] draw_thread_id();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 4)
            return '0;
        if (roll < 12 || offered_ids.size() == 0)
            return ID_W'($urandom);
        return offered_ids[$urandom_range(0, offered_ids.size() - 1)];
    endfunction

    task automatic queue_random_cmds(input int count);
        int roll;
        logic [CMD_W-1:0] c;
        logic [ID_W-1:0] id;
        logic [PRIO_W-1:0] prio;
        logic [STATE_W-1:0] ns;
        logic signed [SUSP_W-1:0] susp;
        for (int k = 0; k < count; k++) begin
            roll = $urandom_range(0, 99);
            id = draw_thread_id();
            // mostly within or just over the priority ceiling so ties and cutoffs come up
            prio = ($urandom_range(0, 4) == 0) ? PRIO_W'($urandom)
                                              : PRIO_W'($urandom_range(0, PRIORITY_MAX + 4));
            ns = ($urandom_range(0, 1) == 0) ? STATE_W'($urandom)
                                            : STATE_W'(1 << $urandom_range(0, STATE_W - 1));
            case ($urandom_range(0, 4))
                0: susp = 32'sd0;
                1: susp = 32'sd1;
                2: susp = SUSP_W'(-int'($urandom_range(1, 1000)));
                3: susp = SUSP_W'($urandom);
                default: susp = 32'sd0;
            endcase
            if (roll < 5) begin
                c = CMD_CREATE;
                if ($urandom_range(0, 2) != 0 && offered_ids.size() < 24) begin
                    id = ID_W'($urandom);
                    if (id != '0)
                        offered_ids.push_back(id);
                end
            end else if (roll < 25)
                c = CMD_READ_STATE;
            else if (roll < 50)
                c = CMD_WRITE_STATE;
            else if (roll < 75)
                c = CMD_WRITE_SUSP;
            else if (roll < 96)
                c = CMD_PICK;
            else
                c = CMD_W'($urandom_range(CMD_RESERVED_FIRST, CMD_RESERVED_LAST));
            queue_cmd(c, id, prio, ns, susp);
        end
    endtask

    task automatic wait_drained();
        while (accepted_count != queued_count || expected_resps.size() != 0)
            @(posedge clk);
    endtask

    // writes both masks back to back, valid held high between the two items
    task automatic set_masks(input logic [STATE_W-1:0] rdy, input logic [STATE_W-1:0] run);
        cfg_index <= CFG_READY_MASK;
        cfg_data <= rdy;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        ready_mask_m = rdy;
        cfg_index <= CFG_RUNNING_MASK;
        cfg_data <= run;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        running_mask_m = run;
        cfg_valid <= 1'b0;
    endtask

    // input driver
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                expected_resps.push_back(schedule_command(drv_cmd));
                accepted_count++;
            end
            if (!in_valid || in_ready) begin
                send_now = 1'b0;
                if (send_gap > 0)
                    send_gap--;
                else if (!calm && $urandom_range(0, 19) == 0)
                    send_gap = $urandom_range(1, 15) - 1;
                else if (pending_cmds.size() > 0)
                    send_now = 1'b1;
                if (send_now) begin
                    drv_cmd = pending_cmds.pop_front();
                    cmd <= drv_cmd.cmd;
                    thread_id <= drv_cmd.id;
                    priority_req <= drv_cmd.prio;
                    new_state <= drv_cmd.nstate;
                    suspend_value <= drv_cmd.susp;
                end
                in_valid <= send_now;
            end
        end
    end

    // result side backpressure, with long hold-offs so the block fills up
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else if (next_hold_mark > 0 && results_seen >= next_hold_mark) begin
            hold_left = HOLD_CYCLES - 1;
            next_hold_mark = (next_hold_mark < 900) ? 900 : 0;
            out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 19) == 0) begin
            stall_left = $urandom_range(1, 15) - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // result checker
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            results_seen++;
            if (expected_resps.size() == 0) begin
                $error("result with nothing expected: ok %0d state_value %0h picked_thread %0h",
                       ok, state_value, picked_thread);
                fail_count++;
            end else begin
                mon_resp = expected_resps.pop_front();
                if (ok !== mon_resp.ok) begin
                    $error("ok: expected %0d, got %0d", mon_resp.ok, ok);
                    fail_count++;
                end
                if (state_value !== mon_resp.state_bits) begin
                    $error("state_value: expected %0h, got %0h", mon_resp.state_bits, state_value);
                    fail_count++;
                end
                if (picked_thread !== mon_resp.picked_id) begin
                    $error("picked_thread: expected %0h, got %0h",
                           mon_resp.picked_id, picked_thread);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
                $error("no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end else
                quiet_cycles++;
        end
    end

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // empty table, zero and unknown ids, extremes of the fields
        queue_cmd(CMD_PICK, '0, '0, '0, '0);
        queue_cmd(CMD_READ_STATE, '0, '0, '0, '0);
        queue_cmd(CMD_WRITE_STATE, '0, '0, 16'hffff, '0);
        queue_cmd(CMD_WRITE_SUSP, '0, '0, '0, 32'sh7fffffff);
        queue_cmd(CMD_WRITE_STATE, 32'd5, '0, 16'h0001, '0);
        queue_cmd(CMD_CREATE, '0, '0, '0, '0);
        queue_cmd(CMD_CREATE, 32'hffffffff, 8'hff, '0, '0);
        queue_cmd(CMD_CREATE, 32'd1, 8'd0, '0, '0);
        queue_cmd(CMD_CREATE, 32'd1, 8'd3, '0, '0);
        queue_cmd(CMD_READ_STATE, 32'd1, '0, '0, '0);
        // new threads start suspended
        queue_cmd(CMD_PICK, '0, '0, '0, '0);
        queue_cmd(CMD_WRITE_SUSP, 32'd1, '0, '0, 32'sd0);
        queue_cmd(CMD_WRITE_SUSP, 32'hffffffff, '0, '0, 32'sh80000000);
        queue_cmd(CMD_PICK, '0, '0, '0, '0);
        queue_cmd(CMD_WRITE_SUSP, 32'd1, '0, '0, 32'sh7fffffff);
        // only the priority 255 thread is runnable, and it is over the ceiling
        queue_cmd(CMD_PICK, '0, '0, '0, '0);
        queue_cmd(CMD_WRITE_STATE, 32'd1, '0, 16'h0000, '0);
        queue_cmd(CMD_WRITE_SUSP, 32'd1, '0, '0, -32'sd1);
        queue_cmd(CMD_PICK, '0, '0, '0, '0);
        queue_cmd(CMD_WRITE_STATE, 32'd1, '0, 16'h0002, '0);
        queue_cmd(CMD_PICK, '0, '0, '0, '0);
        queue_cmd(CMD_RESERVED_LAST, 32'hffffffff, 8'hff, 16'hffff, -32'sd1);
        queue_cmd(CMD_RESERVED_FIRST, '0, '0, '0, '0);
        queue_cmd(CMD_READ_STATE, 32'd2, '0, '0, '0);
        queue_cmd(CMD_CREATE, 32'd2, PRIO_W'(PRIORITY_MAX), '0, '0);
        offered_ids.push_back(32'd1);
        offered_ids.push_back(32'd2);
        offered_ids.push_back(32'hffffffff);

        queue_random_cmds(350);
        wait_drained();
        set_masks(16'hffff, 16'hffff);
        queue_random_cmds(350);
        wait_drained();
        set_masks(16'h0000, 16'h0000);
        queue_random_cmds(250);
        wait_drained();
        set_masks(STATE_W'($urandom), STATE_W'($urandom));
        queue_random_cmds(350);
        wait_drained();
        set_masks(16'h8000, 16'h0001);
        calm = 1'b1;
        queue_random_cmds(450);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/ttpp_pkg.sv
hw/rtl/ttpp_ctrl.sv
hw/rtl/ttpp_dp.sv
hw/rtl/thread_table_priority_picker.sv
tb/sv/tb.sv
